>>> rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types, command and status codes for the alias address table.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ALIAS_W         = 40;
    localparam int OCTET_W         = 8;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 3;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALIAS_EXISTS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDR_EXISTS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd4;

    typedef struct packed {
        logic [ALIAS_W-1:0] hi;
        logic [ALIAS_W-1:0] lo;
        logic [OCTET_W-1:0] oa;
        logic [OCTET_W-1:0] ob;
        logic [OCTET_W-1:0] oc;
        logic [OCTET_W-1:0] od;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_run;
        logic finish;
        logic shift_run;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic need_shift;
        logic shift_done;
    } t_stat;

endpackage

>>> rtl/aat_ram.sv
// ----------------------------------------------------------------------------
// aat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aat_ram #(
    parameter int WIDTH = aat_pkg::ENTRY_W,
    parameter int DEPTH = aat_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/aat_ctrl.sv
// ----------------------------------------------------------------------------
// aat_ctrl
// Command sequencer: accept, scan the table, report, close the gap on delete.
// ----------------------------------------------------------------------------
module aat_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [aat_pkg::CMD_W-1:0]      i_cmd,
    input  aat_pkg::t_stat                 i_stat,
    output logic                           o_in_ready,
    output aat_pkg::t_ctl                  o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_SHIFT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
                if (i_in_valid && (i_cmd <= aat_pkg::CMD_LIST)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctl.finish = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = i_stat.need_shift ? S_SHIFT : S_IDLE;
                end
            end
            S_SHIFT: begin
                o_ctl.shift_run = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/aat_dp.sv
// ----------------------------------------------------------------------------
// aat_dp
// Datapath: request register, entry memory, scan compare, result register.
// ----------------------------------------------------------------------------
module aat_dp #(
    parameter int TABLE_DEPTH = aat_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  aat_pkg::t_ctl                    i_ctl,
    output aat_pkg::t_stat                   o_stat,
    input  logic [aat_pkg::CMD_W-1:0]        i_cmd,
    input  logic [aat_pkg::ALIAS_W-1:0]      i_alias_high,
    input  logic [aat_pkg::ALIAS_W-1:0]      i_alias_low,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_a,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_b,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_c,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_d,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [aat_pkg::STATUS_W-1:0]     o_status,
    output logic [aat_pkg::ALIAS_W-1:0]      o_found_alias_high,
    output logic [aat_pkg::ALIAS_W-1:0]      o_found_alias_low,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_a,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_b,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_c,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_d,
    output logic                             o_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NCHAR = 2 * aat_pkg::ALIAS_W / aat_pkg::OCTET_W;
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    // zero every character after the first zero character
    function automatic logic [2*aat_pkg::ALIAS_W-1:0] canon_alias(
        input logic [2*aat_pkg::ALIAS_W-1:0] a
    );
        logic [2*aat_pkg::ALIAS_W-1:0] c;
        logic                          ended;
        c     = a;
        ended = 1'b0;
        for (int i = 0; i < NCHAR; i++) begin
            if (ended) begin
                c[2*aat_pkg::ALIAS_W-1-aat_pkg::OCTET_W*i -: aat_pkg::OCTET_W] = '0;
            end else if (a[2*aat_pkg::ALIAS_W-1-aat_pkg::OCTET_W*i -: aat_pkg::OCTET_W]
                         == '0) begin
                ended = 1'b1;
            end
        end
        return c;
    endfunction

    logic [2*aat_pkg::ALIAS_W-1:0] w_canon;
    aat_pkg::t_entry               w_in_req;

    // request and scan state
    logic [aat_pkg::CMD_W-1:0] r_cmd;
    aat_pkg::t_entry           r_req;
    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_ptr;
    logic [CW-1:0]             r_left;
    logic                      r_cvld;
    logic [AW-1:0]             r_cidx;
    logic                      r_found;
    logic [AW-1:0]             r_idx;
    aat_pkg::t_entry           r_ent;
    logic                      r_addr_found;
    logic                      r_pend_vld;
    aat_pkg::t_entry           r_pend;
    logic [CW-1:0]             r_sptr;
    logic                      r_svld;
    logic [AW-1:0]             r_waddr;

    // result register
    logic                          r_ovld;
    logic [aat_pkg::STATUS_W-1:0]  r_ostat;
    aat_pkg::t_entry               r_oent;
    logic                          r_olast;

    aat_pkg::t_entry w_rd;
    logic [aat_pkg::ENTRY_W-1:0] w_rdata;
    logic            w_alias_hit;
    logic            w_addr_hit;
    logic            w_ab_hit;
    logic            w_is_list;
    logic            w_out_free;
    logic            w_blk;
    logic            w_adv;
    logic            w_issue;
    logic            w_take;
    logic            w_sh_issue;
    logic            w_emit_pend;
    logic            w_oload;
    logic [CW-1:0]   w_cnt_m1;
    logic [CW-1:0]   w_sptr_m1;

    logic [aat_pkg::STATUS_W-1:0] f_stat;
    aat_pkg::t_entry              f_ent;
    logic                         f_we;
    logic [AW-1:0]                f_waddr;
    logic                         f_inc;
    logic                         f_dec;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [aat_pkg::ENTRY_W-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    assign w_canon  = canon_alias({i_alias_high, i_alias_low});
    assign w_in_req = '{hi: w_canon[2*aat_pkg::ALIAS_W-1:aat_pkg::ALIAS_W],
                        lo: w_canon[aat_pkg::ALIAS_W-1:0],
                        oa: i_octet_a, ob: i_octet_b, oc: i_octet_c, od: i_octet_d};

    assign w_rd        = aat_pkg::t_entry'(w_rdata);
    assign w_alias_hit = (w_rd.hi == r_req.hi) && (w_rd.lo == r_req.lo);
    assign w_ab_hit    = (w_rd.oa == r_req.oa) && (w_rd.ob == r_req.ob);
    assign w_addr_hit  = w_ab_hit && (w_rd.oc == r_req.oc) && (w_rd.od == r_req.od);
    assign w_is_list   = (r_cmd == aat_pkg::CMD_LIST);
    assign w_out_free  = !r_ovld || i_out_ready;

    // hold the scan while a completed list match cannot be handed out
    assign w_blk      = r_cvld && w_is_list && w_ab_hit && r_pend_vld && !w_out_free;
    assign w_adv      = i_ctl.scan_run && !w_blk;
    assign w_issue    = w_adv && (r_left != '0);
    assign w_take     = w_adv && r_cvld;
    assign w_sh_issue = i_ctl.shift_run && (r_sptr <= r_count);
    assign w_emit_pend = w_take && w_is_list && w_ab_hit && r_pend_vld;
    assign w_oload    = w_emit_pend || i_ctl.finish;
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_sptr_m1  = r_sptr - CW'(1);

    always_comb begin
        f_stat  = aat_pkg::ST_NOT_FOUND;
        f_ent   = '0;
        f_we    = 1'b0;
        f_waddr = r_idx;
        f_inc   = 1'b0;
        f_dec   = 1'b0;
        case (r_cmd)
            aat_pkg::CMD_ADD: begin
                f_ent   = r_req;
                f_waddr = r_count[AW-1:0];
                if (r_found) begin
                    f_stat = aat_pkg::ST_ALIAS_EXISTS;
                end else if (r_addr_found) begin
                    f_stat = aat_pkg::ST_ADDR_EXISTS;
                end else if (r_count == FULL) begin
                    f_stat = aat_pkg::ST_TABLE_FULL;
                end else begin
                    f_stat = aat_pkg::ST_OK;
                    f_we   = 1'b1;
                    f_inc  = 1'b1;
                end
            end
            aat_pkg::CMD_LOOKUP: begin
                if (r_found) begin
                    f_stat = aat_pkg::ST_OK;
                    f_ent  = r_ent;
                end
            end
            aat_pkg::CMD_UPDATE: begin
                if (r_found && r_addr_found) begin
                    f_stat = aat_pkg::ST_ADDR_EXISTS;
                    f_ent  = r_ent;
                end else if (r_found) begin
                    f_stat   = aat_pkg::ST_OK;
                    f_ent    = r_ent;
                    f_ent.oa = r_req.oa;
                    f_ent.ob = r_req.ob;
                    f_ent.oc = r_req.oc;
                    f_ent.od = r_req.od;
                    f_we     = 1'b1;
                end
            end
            aat_pkg::CMD_DELETE: begin
                if (r_found) begin
                    f_stat = aat_pkg::ST_OK;
                    f_ent  = r_ent;
                    f_dec  = 1'b1;
                end
            end
            aat_pkg::CMD_LIST: begin
                if (r_pend_vld) begin
                    f_stat = aat_pkg::ST_OK;
                    f_ent  = r_pend;
                end else begin
                    f_ent.oa = r_req.oa;
                    f_ent.ob = r_req.ob;
                end
            end
            default: begin
                f_stat = aat_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // physical index grows with age reversed: the newest entry sits at count - 1
    assign w_we    = (i_ctl.finish && f_we) || (i_ctl.shift_run && r_svld);
    assign w_waddr = i_ctl.shift_run ? r_waddr : f_waddr;
    assign w_wdata = i_ctl.shift_run ? w_rdata : aat_pkg::ENTRY_W'(f_ent);
    assign w_re    = w_issue || w_sh_issue;
    assign w_raddr = i_ctl.shift_run ? r_sptr[AW-1:0] : r_ptr;

    aat_ram #(
        .WIDTH (aat_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_left       <= '0;
            r_cvld       <= 1'b0;
            r_found      <= 1'b0;
            r_addr_found <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_svld       <= 1'b0;
            r_ovld       <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_cmd        <= i_cmd;
                r_req        <= w_in_req;
                r_ptr        <= w_cnt_m1[AW-1:0];
                r_left       <= r_count;
                r_cvld       <= 1'b0;
                r_found      <= 1'b0;
                r_addr_found <= 1'b0;
                r_pend_vld   <= 1'b0;
            end
            if (w_adv) begin
                r_cvld <= w_issue;
                if (w_issue) begin
                    r_cidx <= r_ptr;
                    r_ptr  <= r_ptr - AW'(1);
                    r_left <= r_left - CW'(1);
                end
            end
            if (w_take) begin
                if (w_alias_hit) begin
                    r_found <= 1'b1;
                    r_idx   <= r_cidx;
                    r_ent   <= w_rd;
                end
                if (w_addr_hit) begin
                    r_addr_found <= 1'b1;
                end
                if (w_is_list && w_ab_hit) begin
                    r_pend     <= w_rd;
                    r_pend_vld <= 1'b1;
                end
            end
            if (i_ctl.finish) begin
                if (f_inc) begin
                    r_count <= r_count + CW'(1);
                end else if (f_dec) begin
                    r_count <= w_cnt_m1;
                end
                r_sptr <= CW'(r_idx) + CW'(1);
            end
            if (w_sh_issue) begin
                r_sptr  <= r_sptr + CW'(1);
                r_waddr <= w_sptr_m1[AW-1:0];
            end
            r_svld <= w_sh_issue;
            if (w_oload) begin
                r_ovld  <= 1'b1;
                r_ostat <= i_ctl.finish ? f_stat : aat_pkg::ST_OK;
                r_oent  <= i_ctl.finish ? f_ent : r_pend;
                r_olast <= i_ctl.finish;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_stat.scan_done  = (r_left == '0) && !r_cvld;
    assign o_stat.out_free   = w_out_free;
    assign o_stat.need_shift = (r_cmd == aat_pkg::CMD_DELETE) && r_found;
    assign o_stat.shift_done = !(r_sptr <= r_count) && !r_svld;

    assign o_out_valid        = r_ovld;
    assign o_status           = r_ostat;
    assign o_found_alias_high = r_oent.hi;
    assign o_found_alias_low  = r_oent.lo;
    assign o_out_octet_a      = r_oent.oa;
    assign o_out_octet_b      = r_oent.ob;
    assign o_out_octet_c      = r_oent.oc;
    assign o_out_octet_d      = r_oent.od;
    assign o_last             = r_olast;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count above table depth");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_oload |-> w_out_free)
        else $error("result register overwritten");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.shift_run && r_svld) |-> (CW'(r_waddr) < r_count))
        else $error("shift write beyond live entries");

    a_finish_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish |-> ((r_left == '0) && !r_cvld))
        else $error("result given before scan completed");

endmodule

>>> rtl/alias_address_table.sv
// ----------------------------------------------------------------------------
// alias_address_table
// Alias to four-octet address table, newest first, with add, lookup,
// update, delete and list by first two octets.
// ----------------------------------------------------------------------------
// scan: the table is read one entry per cycle, newest first, except while a list
//   match waits for the output; a request is taken only after the previous one is done
// delete: the entries newer than the deleted one are copied down one place to
//   close the gap
// reset: entry count cleared at once, no clearing pass, memory left undefined
// ----------------------------------------------------------------------------
module alias_address_table #(
    parameter int TABLE_DEPTH = aat_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [aat_pkg::CMD_W-1:0]        i_cmd,
    input  logic [aat_pkg::ALIAS_W-1:0]      i_alias_high,
    input  logic [aat_pkg::ALIAS_W-1:0]      i_alias_low,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_a,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_b,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_c,
    input  logic [aat_pkg::OCTET_W-1:0]      i_octet_d,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [aat_pkg::STATUS_W-1:0]     o_status,
    output logic [aat_pkg::ALIAS_W-1:0]      o_found_alias_high,
    output logic [aat_pkg::ALIAS_W-1:0]      o_found_alias_low,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_a,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_b,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_c,
    output logic [aat_pkg::OCTET_W-1:0]      o_out_octet_d,
    output logic                             o_last
);

    aat_pkg::t_ctl  w_ctl;
    aat_pkg::t_stat w_stat;

    aat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_ctl      (w_ctl)
    );

    aat_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .o_stat             (w_stat),
        .i_cmd              (i_cmd),
        .i_alias_high       (i_alias_high),
        .i_alias_low        (i_alias_low),
        .i_octet_a          (i_octet_a),
        .i_octet_b          (i_octet_b),
        .i_octet_c          (i_octet_c),
        .i_octet_d          (i_octet_d),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_found_alias_high (o_found_alias_high),
        .o_found_alias_low  (o_found_alias_low),
        .o_out_octet_a      (o_out_octet_a),
        .o_out_octet_b      (o_out_octet_b),
        .o_out_octet_c      (o_out_octet_c),
        .o_out_octet_d      (o_out_octet_d),
        .o_last             (o_last)
    );

endmodule
